// ===== rtl/core/idpg_pkg.sv =====
// shared types, constants, microcode table and arithmetic helpers
package idpg_pkg;

  localparam int NODE_BYTES   = 96;
  localparam int MAP_SIDE     = 5;
  localparam int MAP_DEPTH    = MAP_SIDE * MAP_SIDE * NODE_BYTES;
  localparam int MAP_AW       = $clog2(MAP_DEPTH);
  localparam int LEVEL_W      = 8;
  localparam int STEP_W       = 5;
  localparam int PART_W       = 2;
  localparam int NUM_PARTS    = 3;
  localparam int UC_PC_W      = 4;
  localparam logic [15:0] LFSR_TAPS   = 16'hB400;
  localparam logic [15:0] LFSR_RESET  = 16'h0001;
  localparam logic [7:0]  ACCENT_LEVEL = 8'd192;
  localparam logic [7:0]  LEVEL_MAX    = 8'd255;

  // microcode addresses with a fixed meaning
  localparam logic [UC_PC_W-1:0] UC_READS = 4'd12;
  localparam logic [UC_PC_W-1:0] UC_EMIT  = 4'd14;
  localparam logic [UC_PC_W-1:0] UC_MISC  = 4'd15;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_RESTART = 2'd2,
    OP_RESEED  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    DP_NOP,
    DP_LOAD_A,
    DP_TOP,
    DP_BOT
  } dp_op_t;

  typedef struct packed {
    logic                 rd_en;
    logic [PART_W-1:0]    rd_part;
    logic [1:0]           rd_corner;
    dp_op_t               dp_op;
    logic                 fin_en;
    logic [PART_W-1:0]    fin_part;
    logic                 pert_en;
    logic [PART_W-1:0]    pert_part;
    logic                 emit;
    logic                 misc;
    logic                 jump_en;
    logic [UC_PC_W-1:0]   jump_to;
    logic                 last;
  } ctrl_t;

  // program: twelve map reads one per step, blends use read data in the next step
  function automatic ctrl_t ucode_rom(input logic [UC_PC_W-1:0] pc);
    ctrl_t c;
    c = '0;
    c.dp_op = DP_NOP;
    if (pc < UC_READS) begin
      c.rd_en     = 1'b1;
      c.rd_part   = pc[3:2];
      c.rd_corner = pc[1:0];
    end
    case (pc)
      4'd0: begin
        c.pert_en   = 1'b1;
        c.pert_part = 2'd0;
        c.jump_en   = 1'b1;
        c.jump_to   = UC_MISC;
      end
      4'd1: begin
        c.pert_en   = 1'b1;
        c.pert_part = 2'd1;
        c.dp_op     = DP_LOAD_A;
      end
      4'd2: begin
        c.pert_en   = 1'b1;
        c.pert_part = 2'd2;
        c.dp_op     = DP_TOP;
      end
      4'd3:  c.dp_op = DP_LOAD_A;
      4'd4:  c.dp_op = DP_BOT;
      4'd5: begin
        c.dp_op    = DP_LOAD_A;
        c.fin_en   = 1'b1;
        c.fin_part = 2'd0;
      end
      4'd6:  c.dp_op = DP_TOP;
      4'd7:  c.dp_op = DP_LOAD_A;
      4'd8:  c.dp_op = DP_BOT;
      4'd9: begin
        c.dp_op    = DP_LOAD_A;
        c.fin_en   = 1'b1;
        c.fin_part = 2'd1;
      end
      4'd10: c.dp_op = DP_TOP;
      4'd11: c.dp_op = DP_LOAD_A;
      4'd12: c.dp_op = DP_BOT;
      4'd13: begin
        c.fin_en   = 1'b1;
        c.fin_part = 2'd2;
      end
      UC_EMIT: begin
        c.emit = 1'b1;
        c.last = 1'b1;
      end
      UC_MISC: begin
        c.misc = 1'b1;
        c.last = 1'b1;
      end
      default: c.last = 1'b1;
    endcase
    return c;
  endfunction

  // (a*(255-w) + b*w) >> 8
  function automatic logic [7:0] blend8(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] w);
    logic [15:0] s;
    s = 16'({8'b0, a} * {8'b0, LEVEL_MAX - w}) + 16'({8'b0, b} * {8'b0, w});
    return s[15:8];
  endfunction

endpackage

// ===== rtl/core/idpg_in_if.sv =====
// input channel: command beat with tick, map write and restart fields
interface idpg_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  pos_x;
  logic [7:0]  pos_y;
  logic [7:0]  density_kick;
  logic [7:0]  density_snare;
  logic [7:0]  density_hat;
  logic [7:0]  chaos;
  logic [11:0] map_address;
  logic [7:0]  map_byte;

  modport source (
    output valid, opcode, pos_x, pos_y, density_kick, density_snare, density_hat,
           chaos, map_address, map_byte,
    input  ready
  );
  modport sink (
    input  valid, opcode, pos_x, pos_y, density_kick, density_snare, density_hat,
           chaos, map_address, map_byte,
    output ready
  );
endinterface

// ===== rtl/core/idpg_out_if.sv =====
// result channel: triggers, accents and played step of one tick
interface idpg_out_if;
  logic       valid;
  logic       ready;
  logic       kick_trigger;
  logic       snare_trigger;
  logic       hat_trigger;
  logic       kick_accent;
  logic       snare_accent;
  logic       hat_accent;
  logic [4:0] played_step;

  modport source (
    output valid, kick_trigger, snare_trigger, hat_trigger, kick_accent,
           snare_accent, hat_accent, played_step,
    input  ready
  );
  modport sink (
    input  valid, kick_trigger, snare_trigger, hat_trigger, kick_accent,
           snare_accent, hat_accent, played_step,
    output ready
  );
endinterface

// ===== rtl/core/idpg_ram.sv =====
// generic single-write, single-read RAM with registered read data
module idpg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
endmodule

// ===== rtl/core/idpg_seq.sv =====
// microcode sequencer: step counter, conditional jump and control word fetch
module idpg_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           jump_cond,
  input  logic           stall,
  output logic           busy,
  output idpg_pkg::ctrl_t ctrl
);
  import idpg_pkg::*;

  logic               busy_r, busy_nxt;
  logic [UC_PC_W-1:0] pc_r, pc_nxt;
  ctrl_t              word;

  assign word = ucode_rom(pc_r);

  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        pc_nxt   = '0;
      end
    end else if (!stall) begin
      if (word.last) begin
        busy_nxt = 1'b0;
        pc_nxt   = '0;
      end else if (word.jump_en && jump_cond) begin
        pc_nxt = word.jump_to;
      end else begin
        pc_nxt = pc_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

  assign busy = busy_r;
  assign ctrl = busy_r ? word : '0;
endmodule

// ===== rtl/core/interpolated_drum_pattern_generator.sv =====
// top level: interpolated drum pattern generator over a 5x5 map of pattern nodes
//
//   channel   dir  handshake          beat contents
//   in_chan   in   valid/ready        opcode, position, densities, chaos, map write
//   out_chan  out  valid/ready        three triggers, three accents, played step
//   cfg_*     in   cfg_wr_en strobe   lfsr seed, 16 bits
//
// a tick beat runs its accept cycle and then the microcode steps up to the emit step;
// the map RAM's single read port sets their number, twelve reads issued one per step
// a map write, restart or reseed beat runs through accept, dispatch and execute
// in_chan.ready is high whenever the sequencer is idle; a finished result waits
// in the output register, and the next tick stalls only at its emit step if
// that register is still full and out_chan.ready is low
// reset (rst_n low, synchronous) clears step, perturbations and result valid and
// sets lfsr and seed to 1; map contents are undefined until written
module interpolated_drum_pattern_generator (
  input  logic        clk,
  input  logic        rst_n,
  idpg_in_if.sink     in_chan,
  idpg_out_if.source  out_chan,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  import idpg_pkg::*;

  // sequencer
  ctrl_t ctrl;
  logic  busy;
  logic  accept;
  logic  stall;
  logic  emit_fire;

  // captured beat
  opcode_t           op_r;
  logic [7:0]        x_r;
  logic [7:0]        y_r;
  logic [7:0]        dens_r [NUM_PARTS];
  logic [7:0]        chaos_r;
  logic [MAP_AW-1:0] waddr_r;
  logic [7:0]        wbyte_r;

  // pattern state
  logic [STEP_W-1:0] step_r;
  logic [15:0]       lfsr_r, lfsr_nxt;
  logic [15:0]       seed_r;
  logic [7:0]        pert_r [NUM_PARTS];
  logic [7:0]        pert_nxt;

  // mixing datapath
  logic [7:0]        a_r, top_r, bot_r;
  logic [7:0]        wx, wy;
  logic [7:0]        rd_data;
  logic [2:0]        row_sel, col_sel;
  logic [4:0]        node;
  logic [MAP_AW-1:0] rd_addr;
  logic              wr_en;
  logic [13:0]       pert_prod;
  logic [7:0]        lvl;
  logic [8:0]        lvl_sum;
  logic [7:0]        lvl_sat;
  logic              hit, acc;
  logic              trig_r [NUM_PARTS];
  logic              acc_r  [NUM_PARTS];

  // result register
  logic              out_valid_r;
  logic              out_trig_r [NUM_PARTS];
  logic              out_acc_r  [NUM_PARTS];
  logic [STEP_W-1:0] out_step_r;

  assign accept    = in_chan.valid && in_chan.ready;
  assign stall     = ctrl.emit && out_valid_r && !out_chan.ready;
  assign emit_fire = ctrl.emit && !stall;

  idpg_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (accept),
    .jump_cond (op_r != OP_TICK),
    .stall     (stall),
    .busy      (busy),
    .ctrl      (ctrl)
  );

  assign in_chan.ready = !busy;

  // capture the beat; payload only, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r      <= opcode_t'(in_chan.opcode);
      x_r       <= in_chan.pos_x;
      y_r       <= in_chan.pos_y;
      dens_r[0] <= in_chan.density_kick;
      dens_r[1] <= in_chan.density_snare;
      dens_r[2] <= in_chan.density_hat;
      chaos_r   <= in_chan.chaos;
      waddr_r   <= in_chan.map_address;
      wbyte_r   <= in_chan.map_byte;
    end
  end

  // corner address: bit 0 of the corner steps the row (x), bit 1 the column (y)
  assign row_sel = {1'b0, x_r[7:6]} + {2'b0, ctrl.rd_corner[0]};
  assign col_sel = {1'b0, y_r[7:6]} + {2'b0, ctrl.rd_corner[1]};
  assign node    = 5'(row_sel * 5'(MAP_SIDE)) + {2'b0, col_sel};
  assign rd_addr = MAP_AW'(node * MAP_AW'(NODE_BYTES)) + {5'b0, ctrl.rd_part, step_r};

  // map writes beyond the last node are dropped
  assign wr_en = ctrl.misc && (op_r == OP_WRITE) && (waddr_r < MAP_AW'(MAP_DEPTH));

  idpg_ram #(
    .WIDTH (LEVEL_W),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (waddr_r),
    .wr_data (wbyte_r),
    .rd_en   (ctrl.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign wx = {x_r[5:0], 2'b00};
  assign wy = {y_r[5:0], 2'b00};

  // galois lfsr, one shift per part at step zero
  assign lfsr_nxt  = (lfsr_r >> 1) ^ (lfsr_r[0] ? LFSR_TAPS : 16'h0000);
  assign pert_prod = 14'({6'b0, lfsr_nxt[15:8]} * {8'b0, chaos_r[7:2]});
  assign pert_nxt  = {2'b00, pert_prod[13:8]};

  // final mix of one part, perturbation with saturation, threshold compare
  assign lvl     = blend8(top_r, bot_r, wy);
  assign lvl_sum = {1'b0, lvl} + {1'b0, pert_r[ctrl.fin_part]};
  assign lvl_sat = lvl_sum[8] ? LEVEL_MAX : lvl_sum[7:0];
  assign hit     = lvl_sat > ~dens_r[ctrl.fin_part];
  assign acc     = hit && (lvl_sat > ACCENT_LEVEL);

  // datapath registers driven by the control word
  always_ff @(posedge clk) begin
    case (ctrl.dp_op)
      DP_LOAD_A: a_r   <= rd_data;
      DP_TOP:    top_r <= blend8(a_r, rd_data, wx);
      DP_BOT:    bot_r <= blend8(a_r, rd_data, wx);
      default: ;
    endcase
    if (ctrl.fin_en) begin
      trig_r[ctrl.fin_part] <= hit;
      acc_r[ctrl.fin_part]  <= acc;
    end
  end

  // pattern state: step, lfsr, perturbations, seed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= '0;
      lfsr_r    <= LFSR_RESET;
      seed_r    <= LFSR_RESET;
      pert_r[0] <= '0;
      pert_r[1] <= '0;
      pert_r[2] <= '0;
    end else begin
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
      end
      if (ctrl.pert_en && (op_r == OP_TICK) && (step_r == '0)) begin
        lfsr_r                 <= lfsr_nxt;
        pert_r[ctrl.pert_part] <= pert_nxt;
      end
      if (emit_fire) begin
        step_r <= step_r + 1'b1;
      end
      if (ctrl.misc) begin
        case (op_r)
          OP_RESTART: begin
            step_r    <= '0;
            pert_r[0] <= '0;
            pert_r[1] <= '0;
            pert_r[2] <= '0;
          end
          OP_RESEED: begin
            step_r    <= '0;
            pert_r[0] <= '0;
            pert_r[1] <= '0;
            pert_r[2] <= '0;
            lfsr_r    <= (seed_r == 16'h0000) ? LFSR_RESET : seed_r;
          end
          default: ;
        endcase
      end
    end
  end

  // output register parts the result from the next tick's work
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_trig_r[0] <= trig_r[0];
      out_trig_r[1] <= trig_r[1];
      out_trig_r[2] <= trig_r[2];
      out_acc_r[0]  <= acc_r[0];
      out_acc_r[1]  <= acc_r[1];
      out_acc_r[2]  <= acc_r[2];
      out_step_r    <= step_r;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.kick_trigger  = out_trig_r[0];
  assign out_chan.snare_trigger = out_trig_r[1];
  assign out_chan.hat_trigger   = out_trig_r[2];
  assign out_chan.kick_accent   = out_acc_r[0];
  assign out_chan.snare_accent  = out_acc_r[1];
  assign out_chan.hat_accent    = out_acc_r[2];
  assign out_chan.played_step   = out_step_r;

  // each emitted beat advances the pattern step by exactly one
  a_step_advance: assert property (@(posedge clk) disable iff (!rst_n)
    emit_fire |=> step_r == STEP_W'($past(step_r) + 1'b1))
    else $error("step did not advance after a result beat");

  // a new result only appears from the emit step of the program
  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(emit_fire))
    else $error("result valid rose without an emit step");

  // map reads and writes never run outside a program
  a_ram_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.rd_en || wr_en) |-> busy)
    else $error("map access while sequencer idle");

  // ticks never reach the misc step, other opcodes never emit
  a_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.emit && op_r != OP_TICK) == 1'b0 && (ctrl.misc && op_r == OP_TICK) == 1'b0)
    else $error("microcode dispatch mismatch");
endmodule
